### sv/hrl_pkg.sv
// Package for the hex record loader: character codes, field phases, result kinds
// and the structs passed between the loader's modules. Depends on nothing.
package hrl_pkg;

   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NINE    = 8'h39;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_F = 8'h46;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_F = 8'h66;
   // Low nibble of 'A' or 'a' is 1; adding this gives the digit value 10.
   localparam logic [3:0] LETTER_BIAS  = 4'd9;

   typedef enum logic [2:0] {
      PH_COUNT   = 3'd0,
      PH_ADDR_HI = 3'd1,
      PH_ADDR_LO = 3'd2,
      PH_TYPE    = 3'd3,
      PH_DATA    = 3'd4,
      PH_CHECK   = 3'd5
   } phase_type;

   typedef enum logic [1:0] {
      KIND_WRITE = 2'd0,
      KIND_OK    = 2'd1,
      KIND_ERROR = 2'd2,
      KIND_END   = 2'd3
   } kind_type;

   typedef struct packed {
      logic       is_hex;
      logic [3:0] value;
   } digit_type;

   typedef struct packed {
      logic        valid;
      kind_type    kind;
      logic [16:0] address;
      logic [7:0]  data;
      logic [16:0] max_address;
   } result_type;

endpackage

### sv/hex_record_loader.sv
// Top level of the hex record loader: input register, parser and result register.
// Depends on hrl_pkg, hrl_char_decode and hrl_record_fsm.
//
// Usage: the req_ channel carries one ASCII character per transaction. Hex digits
// (upper or lower case) pair into bytes; every other character is dropped without
// a result. Bytes are parsed as records: count, address high, address low, type,
// data bytes, checksum. The rsp_ channel returns one transaction for each data
// byte (a write with its address), one for each good checksum, and one for a
// checksum error or for a record with a nonzero type (end of file). After an
// error or end of file all further characters are swallowed until reset.
// Timing: an accepted character waits in the input register and is parsed as it
// leaves it, which it does when the result register is free or being emptied;
// its result is loaded into the result register and offered on rsp_.
// Throughput: one character per cycle while no result waits, with one state update
// per character in the parser. A result waiting in the output register holds the
// parser, but an empty input register still takes one further character while
// the receiver stalls; after that req_ready drops until the result is taken.
// Reset (synchronous, active high) empties both registers, clears the checksum,
// the highest end address and the halt flag, and readies the parser for a count.
module hex_record_loader (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_char_code,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_kind,
   output logic [16:0] rsp_address,
   output logic [7:0]  rsp_data,
   output logic [16:0] rsp_max_address
);
   import hrl_pkg::*;

   logic        in_valid_ff, in_valid_in;
   logic [7:0]  char_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  kind_ff;
   logic [16:0] address_ff;
   logic [7:0]  data_ff;
   logic [16:0] max_address_ff;

   logic        advance;
   digit_type   digit;
   result_type  result;

   // The held character moves through the parser when the output register is
   // free or is being emptied in this same cycle.
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (advance) begin
         in_valid_in = 1'b0;
      end
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (advance && result.valid) begin
         rsp_valid_in = 1'b1;
      end
   end

   hrl_char_decode u_decode (
      .char_code (char_ff),
      .digit     (digit)
   );

   hrl_record_fsm u_fsm (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .digit   (digit),
      .result  (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers carry no reset; they load only with a valid companion.
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         char_ff <= req_char_code;
      end
      if (advance && result.valid) begin
         kind_ff        <= result.kind;
         address_ff     <= result.address;
         data_ff        <= result.data;
         max_address_ff <= result.max_address;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_kind        = kind_ff;
   assign rsp_address     = address_ff;
   assign rsp_data        = data_ff;
   assign rsp_max_address = max_address_ff;

endmodule

### sv/hrl_char_decode.sv
// Hex digit classifier for the hex record loader.
// Depends on hrl_pkg for the character codes and the digit struct.
module hrl_char_decode (
   input  logic [7:0]        char_code,
   output hrl_pkg::digit_type digit
);
   import hrl_pkg::*;

   always_comb begin
      digit = '0;
      if (char_code >= CHAR_ZERO && char_code <= CHAR_NINE) begin
         digit.is_hex = 1'b1;
         digit.value  = char_code[3:0];
      end else if ((char_code >= CHAR_UPPER_A && char_code <= CHAR_UPPER_F) ||
                   (char_code >= CHAR_LOWER_A && char_code <= CHAR_LOWER_F)) begin
         digit.is_hex = 1'b1;
         digit.value  = char_code[3:0] + LETTER_BIAS;
      end
   end

endmodule

### sv/hrl_record_fsm.sv
// Record parser state for the hex record loader: nibble pairing, field phase,
// checksum, address tracking and result generation. Depends on hrl_pkg.
module hrl_record_fsm (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  hrl_pkg::digit_type  digit,
   output hrl_pkg::result_type result
);
   import hrl_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [3:0]  high_nibble_ff, high_nibble_in;
   logic        nibble_half_ff, nibble_half_in;
   logic [7:0]  record_count_ff, record_count_in;
   logic [15:0] record_address_ff, record_address_in;
   logic [7:0]  data_offset_ff, data_offset_in;
   logic [7:0]  running_sum_ff, running_sum_in;
   logic [16:0] highest_end_ff, highest_end_in;
   logic        halted_ff, halted_in;

   logic        step;
   logic        pair;
   logic [7:0]  byte_value;
   logic [7:0]  sum_next;
   logic [7:0]  offset_next;
   logic [16:0] end_address;

   assign step        = advance && !halted_ff && digit.is_hex;
   assign pair        = step && nibble_half_ff;
   assign byte_value  = {high_nibble_ff, digit.value};
   assign sum_next    = running_sum_ff + byte_value;
   assign offset_next = data_offset_ff + 8'd1;
   assign end_address = {1'b0, record_address_ff[15:8], byte_value} +
                        {9'd0, record_count_ff};

   // Next state.
   always_comb begin
      phase_in          = phase_ff;
      high_nibble_in    = high_nibble_ff;
      nibble_half_in    = nibble_half_ff;
      record_count_in   = record_count_ff;
      record_address_in = record_address_ff;
      data_offset_in    = data_offset_ff;
      running_sum_in    = running_sum_ff;
      highest_end_in    = highest_end_ff;
      halted_in         = halted_ff;
      if (step && !nibble_half_ff) begin
         high_nibble_in = digit.value;
         nibble_half_in = 1'b1;
      end else if (pair) begin
         nibble_half_in = 1'b0;
         running_sum_in = sum_next;
         unique case (phase_ff)
            PH_ADDR_HI: begin
               record_address_in = {byte_value, 8'h00};
               phase_in          = PH_ADDR_LO;
            end
            PH_ADDR_LO: begin
               record_address_in = {record_address_ff[15:8], byte_value};
               if (end_address > highest_end_ff) begin
                  highest_end_in = end_address;
               end
               phase_in = PH_TYPE;
            end
            PH_TYPE: begin
               if (byte_value != 8'd0) begin
                  halted_in = 1'b1;
               end else begin
                  data_offset_in = 8'd0;
                  phase_in = (record_count_ff == 8'd0) ? PH_CHECK : PH_DATA;
               end
            end
            PH_DATA: begin
               data_offset_in = offset_next;
               if (offset_next == record_count_ff) begin
                  phase_in = PH_CHECK;
               end
            end
            PH_CHECK: begin
               if (sum_next != 8'd0) begin
                  halted_in = 1'b1;
               end else begin
                  phase_in = PH_COUNT;
               end
            end
            default: begin
               record_count_in = byte_value;
               phase_in        = PH_ADDR_HI;
            end
         endcase
      end
   end

   // Result for the byte completed in this cycle, if any.
   always_comb begin
      result             = '0;
      result.kind        = KIND_WRITE;
      result.address     = {1'b0, record_address_ff};
      result.max_address = highest_end_ff;
      if (pair) begin
         unique case (phase_ff)
            PH_TYPE: begin
               result.valid = (byte_value != 8'd0);
               result.kind  = KIND_END;
            end
            PH_DATA: begin
               result.valid   = 1'b1;
               result.kind    = KIND_WRITE;
               result.address = {1'b0, record_address_ff} + {9'd0, data_offset_ff};
               result.data    = byte_value;
            end
            PH_CHECK: begin
               result.valid = 1'b1;
               result.kind  = (sum_next != 8'd0) ? KIND_ERROR : KIND_OK;
            end
            default: begin
               result.valid = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff          <= PH_COUNT;
         high_nibble_ff    <= '0;
         nibble_half_ff    <= 1'b0;
         record_count_ff   <= '0;
         record_address_ff <= '0;
         data_offset_ff    <= '0;
         running_sum_ff    <= '0;
         highest_end_ff    <= '0;
         halted_ff         <= 1'b0;
      end else begin
         phase_ff          <= phase_in;
         high_nibble_ff    <= high_nibble_in;
         nibble_half_ff    <= nibble_half_in;
         record_count_ff   <= record_count_in;
         record_address_ff <= record_address_in;
         data_offset_ff    <= data_offset_in;
         running_sum_ff    <= running_sum_in;
         highest_end_ff    <= highest_end_in;
         halted_ff         <= halted_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_halt_sticks: assert property (@(posedge clock) disable iff (reset)
      halted_ff |=> halted_ff)
      else $error("halted flag cleared without reset");

   a_no_result_when_halted: assert property (@(posedge clock) disable iff (reset)
      halted_ff |-> !result.valid)
      else $error("result produced while halted");

   a_stop_sets_halt: assert property (@(posedge clock) disable iff (reset)
      (result.valid && (result.kind == KIND_END || result.kind == KIND_ERROR))
      |=> halted_ff)
      else $error("end or error did not halt the parser");

   a_phase_legal: assert property (@(posedge clock) disable iff (reset)
      phase_ff <= PH_CHECK)
      else $error("field phase left its legal range");
`endif

endmodule
